### rtl/signed_int_to_decimal_ascii_core_defines.svh
// Assertion macros shared by the decimal ASCII converter RTL.
// Included by modules that carry concurrent assertions.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SIDA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sida_pkg.sv
// Package for the decimal ASCII converter: widths, character codes, stage types.
// No dependencies.
`timescale 1ns / 1ps
package sida_pkg;
   localparam int ValueWidth = 32;
   localparam int NumDigits  = 10;
   localparam int DigitWidth = 4;
   localparam int CountWidth = 4;
   localparam logic [7:0] CharMinus = 8'd45;
   localparam logic [7:0] CharZero  = 8'd48;

   typedef logic [DigitWidth-1:0] digit_type;
   typedef digit_type [NumDigits-1:0] digits_type;

   // item as it moves through the digit pipeline
   typedef struct packed {
      logic                  neg;
      logic [ValueWidth-1:0] rem;
      digits_type            digits;
   } conv_type;

   // divide a 32-bit magnitude by ten: reciprocal multiply, exact for all inputs
   function automatic logic [ValueWidth-1:0] div10(input logic [ValueWidth-1:0] x);
      logic [ValueWidth+34:0] prod;
      prod = (ValueWidth+35)'(x) * (ValueWidth+35)'(33'h0CCCCCCCD);
      return prod[ValueWidth+34 -: ValueWidth];
   endfunction
endpackage

### rtl/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII converter, top level.
// Uses sida_pkg, sida_digit_stage and sida_serializer.
//
// req channel: one signed value per item (req_valid/req_stall).
// rsp channel: one ASCII character per item, most significant first; a
// minus sign leads negative values. The final character has rsp_last set
// and rsp_char_count holding the total (1 to 11); zero prints as "0".
// The magnitude passes a ten-stage digit pipeline (one divide by ten per
// stage, by reciprocal multiply), then a serializer emits the characters.
// The first character appears once the item has passed the digit-stage
// registers and been loaded into the serializer, which takes a new number
// as the last character of the previous one is sent on the single output port.
// Reset (synchronous, active high) empties pipeline and serializer.
// rsp_stall holds the current character; back-pressure fills the pipeline
// and then raises req_stall. Nothing is lost or repeated.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_defines.svh"
module signed_int_to_decimal_ascii_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [sida_pkg::ValueWidth-1:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last,
   output logic [3:0]  rsp_char_count
);
   logic               v   [sida_pkg::NumDigits+1];
   logic               st  [sida_pkg::NumDigits+1];
   sida_pkg::conv_type d   [sida_pkg::NumDigits+1];

   // stage input: sign and magnitude
   always_comb begin
      d[0].neg    = req_value[sida_pkg::ValueWidth-1];
      d[0].rem    = req_value[sida_pkg::ValueWidth-1]
                    ? (~req_value + sida_pkg::ValueWidth'(1)) : req_value;
      d[0].digits = '0;
   end
   assign v[0]      = req_valid;
   assign req_stall = st[0];

   for (genvar g = 0; g < sida_pkg::NumDigits; g++) begin : g_stage
      sida_digit_stage u_stage (
         .clock(clock), .reset(reset),
         .in_valid(v[g]), .in_data(d[g]), .in_stall(st[g]),
         .out_valid(v[g+1]), .out_data(d[g+1]), .out_stall(st[g+1])
      );
   end

   sida_serializer u_ser (
      .clock(clock), .reset(reset),
      .in_valid(v[sida_pkg::NumDigits]), .in_data(d[sida_pkg::NumDigits]),
      .in_stall(st[sida_pkg::NumDigits]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last), .rsp_char_count(rsp_char_count)
   );

   `SIDA_ASSERT_IMP(a_code, clock, reset, rsp_valid,
      rsp_char_code == sida_pkg::CharMinus || (rsp_char_code >= sida_pkg::CharZero &&
      rsp_char_code <= sida_pkg::CharZero + 8'd9), "bad character code")
   `SIDA_ASSERT_IMP(a_cnt, clock, reset, rsp_valid && rsp_last,
      rsp_char_count <= 4'd11, "count out of range")
endmodule

### rtl/sida_digit_stage.sv
// One pipeline stage: peels off one decimal digit of the running remainder.
// Depends on sida_pkg.
`timescale 1ns / 1ps
module sida_digit_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sida_pkg::conv_type  in_data,
   output logic                in_stall,
   output logic                out_valid,
   output sida_pkg::conv_type  out_data,
   input  logic                out_stall
);
   logic                 valid_ff, valid_in;
   sida_pkg::conv_type   data_ff, data_in;
   logic [sida_pkg::ValueWidth-1:0] quot;
   logic [sida_pkg::ValueWidth+3:0] prod;

   assign in_stall = valid_ff && out_stall;

   // quotient and remainder digit
   always_comb begin
      quot    = sida_pkg::div10(in_data.rem);
      prod    = (sida_pkg::ValueWidth+4)'(quot) * (sida_pkg::ValueWidth+4)'(10);
      data_in = in_data;
      data_in.rem = quot;
      data_in.digits = {in_data.digits[sida_pkg::NumDigits-2:0],
         sida_pkg::DigitWidth'((sida_pkg::ValueWidth+4)'(in_data.rem) - prod)};
      valid_in = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!in_stall && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### rtl/sida_serializer.sv
// Emits the digits of one finished item as characters, one per cycle while rsp_stall is low.
// Depends on sida_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_defines.svh"
module sida_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sida_pkg::conv_type  in_data,
   output logic                in_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_char_code,
   output logic                rsp_last,
   output logic [3:0]          rsp_char_count
);
   logic                 busy_ff, busy_in;
   logic                 sign_ff, sign_in;
   logic [3:0]           idx_ff, idx_in;     // digit index, counts down
   logic [3:0]           total_ff, total_in;
   sida_pkg::digits_type dig_ff, dig_in;
   logic [3:0]           nd;
   logic                 fire, take;

   // count of significant digits
   always_comb begin
      nd = 4'd1;
      for (int i = 1; i < sida_pkg::NumDigits; i++)
         if (in_data.digits[sida_pkg::NumDigits-1-i] != '0) nd = 4'(i + 1);
   end

   assign fire     = busy_ff && !rsp_stall;
   assign take     = in_valid && (!busy_ff || (fire && !sign_ff && idx_ff == 4'd0));
   assign in_stall = !(!busy_ff || (fire && !sign_ff && idx_ff == 4'd0));

   always_comb begin
      busy_in = busy_ff; sign_in = sign_ff; idx_in = idx_ff;
      total_in = total_ff; dig_in = dig_ff;
      if (fire) begin
         if (sign_ff) sign_in = 1'b0;
         else if (idx_ff == 4'd0) busy_in = 1'b0;
         else idx_in = idx_ff - 4'd1;
      end
      if (take) begin
         busy_in  = 1'b1;
         sign_in  = in_data.neg;
         idx_in   = nd - 4'd1;
         total_in = nd + {3'd0, in_data.neg};
         // after the pipeline digits[k] holds the 10^(9-k) digit, so dig_in[k] gets the 10^k digit
         for (int i = 0; i < sida_pkg::NumDigits; i++)
            dig_in[i] = in_data.digits[sida_pkg::NumDigits-1-i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sign_ff <= sign_in; idx_ff <= idx_in; total_ff <= total_in; dig_ff <= dig_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_char_code  = sign_ff ? sida_pkg::CharMinus
                                   : sida_pkg::CharZero + {4'd0, dig_ff[idx_ff]};
   assign rsp_last       = !sign_ff && idx_ff == 4'd0;
   assign rsp_char_count = rsp_last ? total_ff : 4'd0;

   `SIDA_ASSERT_IMP(a_last_count, clock, reset, rsp_valid && rsp_last,
      rsp_char_count != 4'd0, "last char without count")
   `SIDA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_char_code), "stalled char changed")
   `SIDA_ASSERT_IMP(a_idx, clock, reset, rsp_valid, idx_ff < 4'd10, "digit index range")
endmodule
